[sv/ccc_pkg.sv]
// ccc_pkg: shared constants, codes, pipeline types and helpers for the
// cartesian / cylindrical converter. No dependencies.
package ccc_pkg;

   // defaults for the top-level parameters
   localparam int CORDIC_STAGES_DEF = 20;
   localparam int FRAC_BITS_DEF     = 16;

   // internal number formats
   localparam int GUARD    = 16;  // guard bits on data
   localparam int ANG_FRAC = 30;  // angles are Q.30 radians
   localparam int DW       = 52;  // cordic x / y width, signed
   localparam int AW       = 36;  // angle width, signed
   localparam int REM_W    = 56;  // angle magnitude before modulo reduction
   localparam int HI_W     = 64;  // scaled high word
   localparam int SAT_W    = 64;  // width fed to the saturator
   localparam int GAIN_W   = 30;
   localparam int ATAN_W   = 30;

   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

   localparam logic signed [AW-1:0] PI_ANG      = 36'sd3373259426;
   localparam logic signed [AW-1:0] HALF_PI_ANG = 36'sd1686629713;
   localparam logic signed [AW-1:0] TWO_PI_ANG  = 36'sd6746518852;
   localparam logic signed [AW-1:0] FOLD_HI_ANG = TWO_PI_ANG - HALF_PI_ANG;
   localparam logic [REM_W-1:0]     TWO_PI_REM  = 56'd6746518852;

   // atan(2^-i) in Q.30, truncated
   localparam logic [ATAN_W-1:0] ATAN_TABLE [32] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
      30'h00000001, 30'h00000000
   };

   // coordinate types
   localparam logic TYPE_CART = 1'b0;
   localparam logic TYPE_CYL  = 1'b1;

   // conversion modes
   localparam logic [1:0] MODE_PASS    = 2'd0;
   localparam logic [1:0] MODE_TO_CART = 2'd1;  // rotating cordic
   localparam logic [1:0] MODE_TO_CYL  = 2'd2;  // vectoring cordic

   typedef struct packed {
      logic [1:0]              mode;
      logic                    dst_type;
      logic [31:0]             third;
      logic                    flip;
      logic                    rem_neg;
      logic [REM_W-1:0]        rem;
      logic signed [AW-1:0]    angle;
      logic signed [DW-1:0]    x;
      logic signed [DW-1:0]    y;
   } cordic_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic                    dst_type;
      logic [31:0]             third;
      logic signed [AW-1:0]    angle;
      logic signed [HI_W-1:0]  hi;
      logic signed [DW-1:0]    lo;
   } scaled_type;

   // clip to 32 bits, msb of the result is the clip flag
   function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] v);
      logic [32:0] res;
      if (v > 64'sd2147483647) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sd2147483648) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

[sv/cartesian_cylindrical_converter.sv]
// cartesian_cylindrical_converter: top level of the point converter pipeline.
// Depends on ccc_pkg, ccc_prep, ccc_reduce, ccc_fold, ccc_rotate, ccc_scale,
// ccc_output.
//
// Converts 3D points between cartesian (x, y, z) and cylindrical (rho, phi, z)
// form, all values signed fixed point with FRAC_BITS fraction bits and phi in
// radians. Equal source and target types pass the point through untouched;
// otherwise a CORDIC runs in vectoring mode (to cylindrical, full-quadrant
// atan2, origin gives zero) or rotating mode (to cartesian, any phi reduced
// modulo 2pi). Results that leave the 32-bit range clip and set saturated.
// The block is a fully pipelined datapath: one transaction per clock in and
// out while rsp_ready stays high, with one register stage per CORDIC
// iteration and one per compare-subtract step of the modulo 2pi
// reduction; prep, fold, gain multiply and output rounding take one stage
// each. Every stage carries its own valid bit and a stage holds only when the
// stage after it is full and stalled, so bubbles are squeezed out and a
// stalled result does not block new transactions until the pipe is full.
module cartesian_cylindrical_converter #(
   parameter int CORDIC_STAGES = ccc_pkg::CORDIC_STAGES_DEF,
   parameter int FRAC_BITS     = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request transaction
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_source_type,
   input  logic               req_target_type,
   input  logic signed [31:0] req_first_coord,
   input  logic signed [31:0] req_second_coord,
   input  logic signed [31:0] req_third_coord,
   // response transaction
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_type,
   output logic signed [31:0] rsp_out_first,
   output logic signed [31:0] rsp_out_second,
   output logic signed [31:0] rsp_out_third,
   output logic               rsp_saturated
);

   // number of compare-subtract steps that bring phi below 2pi
   localparam int RED_STEPS = ccc_pkg::ANG_FRAC - FRAC_BITS;

   // reduction chain: index 0 is the prep output, last index feeds the fold
   ccc_pkg::cordic_type red_data  [0:RED_STEPS];
   logic                red_valid [0:RED_STEPS];
   logic                red_ready [0:RED_STEPS];

   // cordic chain: index 0 is the fold output, last index feeds the scaler
   ccc_pkg::cordic_type cor_data  [0:CORDIC_STAGES];
   logic                cor_valid [0:CORDIC_STAGES];
   logic                cor_ready [0:CORDIC_STAGES];

   ccc_pkg::scaled_type scl_data;
   logic                scl_valid;
   logic                scl_ready;

   // decode, origin check, rho * K and phi scaling
   ccc_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .source_type  (req_source_type),
      .target_type  (req_target_type),
      .first_coord  (req_first_coord),
      .second_coord (req_second_coord),
      .third_coord  (req_third_coord),
      .dn_valid     (red_valid[0]),
      .dn_ready     (red_ready[0]),
      .dn_data      (red_data[0])
   );

   // restoring modulo 2pi, largest multiple of 2pi first
   for (genvar k = 0; k < RED_STEPS; k++) begin : g_reduce
      ccc_reduce #(
         .STEP (RED_STEPS - 1 - k)
      ) u_reduce (
         .clock    (clock),
         .reset    (reset),
         .up_valid (red_valid[k]),
         .up_ready (red_ready[k]),
         .up_data  (red_data[k]),
         .dn_valid (red_valid[k+1]),
         .dn_ready (red_ready[k+1]),
         .dn_data  (red_data[k+1])
      );
   end

   // fold into the cordic convergence range
   ccc_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .up_valid (red_valid[RED_STEPS]),
      .up_ready (red_ready[RED_STEPS]),
      .up_data  (red_data[RED_STEPS]),
      .dn_valid (cor_valid[0]),
      .dn_ready (cor_ready[0]),
      .dn_data  (cor_data[0])
   );

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ccc_rotate #(
         .STAGE_IDX (i)
      ) u_rotate (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cor_valid[i]),
         .up_ready (cor_ready[i]),
         .up_data  (cor_data[i]),
         .dn_valid (cor_valid[i+1]),
         .dn_ready (cor_ready[i+1]),
         .dn_data  (cor_data[i+1])
      );
   end

   // gain correction for rho, quadrant sign for x / y
   ccc_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cor_valid[CORDIC_STAGES]),
      .up_ready (cor_ready[CORDIC_STAGES]),
      .up_data  (cor_data[CORDIC_STAGES]),
      .dn_valid (scl_valid),
      .dn_ready (scl_ready),
      .dn_data  (scl_data)
   );

   // rounding, saturation, response register
   ccc_output #(
      .FRAC_BITS (FRAC_BITS)
   ) u_output (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (scl_valid),
      .up_ready    (scl_ready),
      .up_data     (scl_data),
      .dn_valid    (rsp_valid),
      .dn_ready    (rsp_ready),
      .result_type (rsp_result_type),
      .out_first   (rsp_out_first),
      .out_second  (rsp_out_second),
      .out_third   (rsp_out_third),
      .saturated   (rsp_saturated)
   );

endmodule

[sv/ccc_prep.sv]
// ccc_prep: first pipeline stage, decodes the conversion and sets up the
// cordic operands. Depends on ccc_pkg.
module ccc_prep #(
   parameter int FRAC_BITS = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  logic                source_type,
   input  logic                target_type,
   input  logic signed [31:0]  first_coord,
   input  logic signed [31:0]  second_coord,
   input  logic signed [31:0]  third_coord,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ccc_pkg::cordic_type dn_data
);

   localparam int ANG_SHIFT  = ccc_pkg::ANG_FRAC - FRAC_BITS;
   localparam int GAIN_SHIFT = ccc_pkg::ANG_FRAC - ccc_pkg::GUARD;
   localparam int PROD_W     = 32 + ccc_pkg::GAIN_W + 1;

   logic signed [PROD_W-1:0]      gain_prod;
   logic signed [32:0]            b_wide;
   logic [32:0]                   b_mag;
   logic signed [ccc_pkg::DW-1:0] a_ext;
   logic signed [ccc_pkg::DW-1:0] b_ext;
   logic signed [ccc_pkg::DW-1:0] a_guard;
   logic signed [ccc_pkg::DW-1:0] b_guard;
   ccc_pkg::cordic_type           data_in;
   ccc_pkg::cordic_type           data_ff;
   logic                          valid_ff;

   // rho * K, back to data format with guard bits
   assign gain_prod = PROD_W'(first_coord) * $signed({1'b0, ccc_pkg::GAIN_Q30});

   assign b_wide  = 33'(second_coord);
   assign b_mag   = b_wide[32] ? 33'(-b_wide) : b_wide;
   assign a_ext   = ccc_pkg::DW'(first_coord);
   assign b_ext   = ccc_pkg::DW'(second_coord);
   assign a_guard = a_ext <<< ccc_pkg::GUARD;
   assign b_guard = b_ext <<< ccc_pkg::GUARD;

   always_comb begin
      data_in          = '0;
      data_in.dst_type = target_type;
      data_in.third    = third_coord;
      if (source_type == target_type) begin
         data_in.mode = ccc_pkg::MODE_PASS;
         data_in.x    = a_ext;
         data_in.y    = b_ext;
      end else if (source_type == ccc_pkg::TYPE_CYL) begin
         data_in.mode    = ccc_pkg::MODE_TO_CART;
         data_in.x       = ccc_pkg::DW'(gain_prod >>> GAIN_SHIFT);
         data_in.rem     = ccc_pkg::REM_W'(b_mag) << ANG_SHIFT;
         data_in.rem_neg = second_coord[31];
      end else if (first_coord == 32'sd0 && second_coord == 32'sd0) begin
         // origin: rho and phi are both zero
         data_in.mode = ccc_pkg::MODE_PASS;
      end else begin
         data_in.mode = ccc_pkg::MODE_TO_CYL;
         if (first_coord[31]) begin
            // left half plane: turn by pi, the offset seeds the angle
            data_in.x     = -a_guard;
            data_in.y     = -b_guard;
            data_in.angle = second_coord[31] ? -ccc_pkg::PI_ANG : ccc_pkg::PI_ANG;
         end else begin
            data_in.x = a_guard;
            data_in.y = b_guard;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[sv/ccc_reduce.sv]
// ccc_reduce: one restoring step of the angle reduction modulo 2pi.
// Depends on ccc_pkg.
module ccc_reduce #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  ccc_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ccc_pkg::cordic_type dn_data
);

   localparam logic [ccc_pkg::REM_W-1:0] SUB_VAL = ccc_pkg::TWO_PI_REM << STEP;

   ccc_pkg::cordic_type data_in;
   ccc_pkg::cordic_type data_ff;
   logic                valid_ff;

   always_comb begin
      data_in = up_data;
      if (up_data.mode == ccc_pkg::MODE_TO_CART && up_data.rem >= SUB_VAL) begin
         data_in.rem = up_data.rem - SUB_VAL;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[sv/ccc_fold.sv]
// ccc_fold: folds the reduced angle into [-pi/2, pi/2] and restores its sign.
// Depends on ccc_pkg.
module ccc_fold (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  ccc_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ccc_pkg::cordic_type dn_data
);

   logic signed [ccc_pkg::AW-1:0] mag;
   logic signed [ccc_pkg::AW-1:0] folded;
   logic                          flip;
   ccc_pkg::cordic_type           data_in;
   ccc_pkg::cordic_type           data_ff;
   logic                          valid_ff;

   // magnitude is below 2pi here
   assign mag = $signed({1'b0, up_data.rem[ccc_pkg::AW-2:0]});

   always_comb begin
      if (mag <= ccc_pkg::HALF_PI_ANG) begin
         folded = mag;
         flip   = 1'b0;
      end else if (mag < ccc_pkg::FOLD_HI_ANG) begin
         folded = mag - ccc_pkg::PI_ANG;
         flip   = 1'b1;
      end else begin
         folded = mag - ccc_pkg::TWO_PI_ANG;
         flip   = 1'b0;
      end
      data_in = up_data;
      if (up_data.mode == ccc_pkg::MODE_TO_CART) begin
         data_in.angle = up_data.rem_neg ? -folded : folded;
         data_in.flip  = flip;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[sv/ccc_rotate.sv]
// ccc_rotate: one cordic micro-rotation, rotating or vectoring by mode.
// Depends on ccc_pkg.
module ccc_rotate #(
   parameter int STAGE_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  ccc_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ccc_pkg::cordic_type dn_data
);

   localparam logic [4:0] TBL_IDX = 5'(STAGE_IDX % 32);
   localparam logic signed [ccc_pkg::AW-1:0] ATAN_STEP =
      $signed({{(ccc_pkg::AW - ccc_pkg::ATAN_W){1'b0}}, ccc_pkg::ATAN_TABLE[TBL_IDX]});

   logic signed [ccc_pkg::DW-1:0] x_sh;
   logic signed [ccc_pkg::DW-1:0] y_sh;
   logic                          ccw;
   ccc_pkg::cordic_type           data_in;
   ccc_pkg::cordic_type           data_ff;
   logic                          valid_ff;

   assign x_sh = up_data.x >>> STAGE_IDX;
   assign y_sh = up_data.y >>> STAGE_IDX;
   // rotating drives the angle to zero, vectoring drives y to zero
   assign ccw  = (up_data.mode == ccc_pkg::MODE_TO_CART) ? !up_data.angle[ccc_pkg::AW-1]
                                                         : up_data.y[ccc_pkg::DW-1];

   always_comb begin
      data_in = up_data;
      if (up_data.mode != ccc_pkg::MODE_PASS) begin
         if (ccw) begin
            data_in.x     = up_data.x - y_sh;
            data_in.y     = up_data.y + x_sh;
            data_in.angle = up_data.angle - ATAN_STEP;
         end else begin
            data_in.x     = up_data.x + y_sh;
            data_in.y     = up_data.y - x_sh;
            data_in.angle = up_data.angle + ATAN_STEP;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[sv/ccc_scale.sv]
// ccc_scale: gain multiply for rho and quadrant sign fix for x / y.
// Depends on ccc_pkg.
module ccc_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  ccc_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output ccc_pkg::scaled_type dn_data
);

   localparam int XH_W = 33;  // vectoring x stays below 2^49
   localparam int HP_W = XH_W + ccc_pkg::GAIN_W;
   localparam int LP_W = ccc_pkg::GUARD + ccc_pkg::GAIN_W;

   logic [XH_W-1:0]               xh;
   logic [ccc_pkg::GUARD-1:0]     xl;
   logic [HP_W-1:0]               hi_prod;
   logic [LP_W-1:0]               lo_prod;
   logic signed [ccc_pkg::DW-1:0] x_fix;
   logic signed [ccc_pkg::DW-1:0] y_fix;
   ccc_pkg::scaled_type           data_in;
   ccc_pkg::scaled_type           data_ff;
   logic                          valid_ff;

   assign xh      = up_data.x[ccc_pkg::GUARD+XH_W-1:ccc_pkg::GUARD];
   assign xl      = up_data.x[ccc_pkg::GUARD-1:0];
   assign hi_prod = HP_W'(xh) * HP_W'(ccc_pkg::GAIN_Q30);
   assign lo_prod = LP_W'(xl) * LP_W'(ccc_pkg::GAIN_Q30);
   assign x_fix   = up_data.flip ? -up_data.x : up_data.x;
   assign y_fix   = up_data.flip ? -up_data.y : up_data.y;

   always_comb begin
      data_in.mode     = up_data.mode;
      data_in.dst_type = up_data.dst_type;
      data_in.third    = up_data.third;
      data_in.angle    = up_data.angle;
      case (up_data.mode)
         ccc_pkg::MODE_TO_CYL: begin
            data_in.hi = $signed(ccc_pkg::HI_W'(hi_prod));
            data_in.lo = $signed(ccc_pkg::DW'(lo_prod));
         end
         ccc_pkg::MODE_TO_CART: begin
            data_in.hi = ccc_pkg::HI_W'(x_fix);
            data_in.lo = y_fix;
         end
         default: begin
            data_in.hi = ccc_pkg::HI_W'(up_data.x);
            data_in.lo = up_data.y;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[sv/ccc_output.sv]
// ccc_output: rounding, saturation and the result register.
// Depends on ccc_pkg.
module ccc_output #(
   parameter int FRAC_BITS = ccc_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  ccc_pkg::scaled_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output logic                result_type,
   output logic signed [31:0]  out_first,
   output logic signed [31:0]  out_second,
   output logic signed [31:0]  out_third,
   output logic                saturated
);

   localparam int SW     = ccc_pkg::SAT_W;
   localparam int PHI_SH = ccc_pkg::ANG_FRAC - FRAC_BITS;
   localparam logic signed [SW-1:0] RHO_HALF   = 64'sd1 <<< (ccc_pkg::ANG_FRAC - 1);
   localparam logic signed [SW-1:0] GUARD_HALF = 64'sd1 <<< (ccc_pkg::GUARD - 1);
   localparam logic signed [SW-1:0] PHI_HALF   = (64'sd1 <<< PHI_SH) >>> 1;

   logic signed [SW-1:0] rho_sum;
   logic signed [SW-1:0] rho_val;
   logic signed [SW-1:0] phi_val;
   logic signed [SW-1:0] cart_x;
   logic signed [SW-1:0] cart_y;
   logic [32:0]          sat_a;
   logic [32:0]          sat_b;
   logic                 result_type_in, result_type_ff;
   logic [31:0]          out_first_in, out_first_ff;
   logic [31:0]          out_second_in, out_second_ff;
   logic [31:0]          out_third_ff;
   logic                 saturated_in, saturated_ff;
   logic                 valid_ff;

   assign rho_sum = up_data.hi + SW'(up_data.lo >>> ccc_pkg::GUARD) + RHO_HALF;
   assign rho_val = rho_sum >>> ccc_pkg::ANG_FRAC;
   assign phi_val = (SW'(up_data.angle) + PHI_HALF) >>> PHI_SH;
   assign cart_x  = (up_data.hi + GUARD_HALF) >>> ccc_pkg::GUARD;
   assign cart_y  = (SW'(up_data.lo) + GUARD_HALF) >>> ccc_pkg::GUARD;

   always_comb begin
      case (up_data.mode)
         ccc_pkg::MODE_TO_CYL: begin
            sat_a = ccc_pkg::sat32(rho_val);
            sat_b = ccc_pkg::sat32(phi_val);
         end
         ccc_pkg::MODE_TO_CART: begin
            sat_a = ccc_pkg::sat32(cart_x);
            sat_b = ccc_pkg::sat32(cart_y);
         end
         default: begin
            sat_a = {1'b0, up_data.hi[31:0]};
            sat_b = {1'b0, up_data.lo[31:0]};
         end
      endcase
      result_type_in = up_data.dst_type;
      out_first_in   = sat_a[31:0];
      out_second_in  = sat_b[31:0];
      saturated_in   = sat_a[32] | sat_b[32];
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         result_type_ff <= result_type_in;
         out_first_ff   <= out_first_in;
         out_second_ff  <= out_second_in;
         out_third_ff   <= up_data.third;
         saturated_ff   <= saturated_in;
      end
   end

   assign dn_valid    = valid_ff;
   assign result_type = result_type_ff;
   assign out_first   = $signed(out_first_ff);
   assign out_second  = $signed(out_second_ff);
   assign out_third   = $signed(out_third_ff);
   assign saturated   = saturated_ff;

endmodule
